### rtl/cct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and codes of the character class tokenizer: result kinds,
// token types, the byte class bundle and the result word layout.
// ----------------------------------------------------------------------------
package cct_pkg;

    // what a result word reports
    typedef enum logic [1:0] {
        KIND_SPACE = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_DROP  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    // class of the token a byte belongs to
    typedef enum logic [1:0] {
        TYPE_WORD    = 2'd0,
        TYPE_NUMBER  = 2'd1,
        TYPE_PUNCT   = 2'd2,
        TYPE_UNKNOWN = 2'd3
    } token_type_t;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // class flags of one byte, from the classifier to the lexer core
    typedef struct packed {
        logic       nul;
        logic       space;
        logic       digit;
        logic       alpha;
        logic       punct;
        logic       dot;
        logic [7:0] lowered;
    } char_class_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        token_type_t token_type;
        logic [7:0]  char_out;
        logic        token_start;
        logic [5:0]  token_index;
        logic [6:0]  token_total;
    } result_t;

endpackage

### rtl/cct_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_byte_if
// Input channel: one byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

### rtl/cct_token_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_token_if
// Result channel: one classified byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cct_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] token_type;
    logic [7:0] char_out;
    logic       token_start;
    logic [5:0] token_index;
    logic [6:0] token_total;

    modport source (
        output valid, output kind, output token_type, output char_out,
        output token_start, output token_index, output token_total,
        input  ready
    );
    modport sink (
        input  valid, input kind, input token_type, input char_out,
        input  token_start, input token_index, input token_total,
        output ready
    );
endinterface

### rtl/cct_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_classify
// Byte classifier: sorts one byte into its character class and gives the
// lower case form of letters.
// ----------------------------------------------------------------------------
module cct_classify
    import cct_pkg::*;
(
    input  logic [7:0]  char_in,
    output char_class_t cls
);

    logic upper;
    logic lower;

    // range tests
    always_comb
    begin
        upper       = char_in inside {[8'd65:8'd90]};
        lower       = char_in inside {[8'd97:8'd122]};
        cls.nul     = (char_in == CHAR_NUL);
        cls.space   = char_in inside {8'd32, [8'd9:8'd13]};
        cls.digit   = char_in inside {[8'd48:8'd57]};
        cls.alpha   = upper || lower;
        cls.punct   = (char_in inside {[8'd33:8'd126]}) && !cls.digit && !cls.alpha;
        cls.dot     = (char_in == CHAR_DOT);
        // upper case letters differ from lower case only in bit 5
        cls.lowered = upper ? (char_in | 8'h20) : char_in;
    end

endmodule

### rtl/cct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_core
// Lexer core: holds the scan state and works out the result word of one
// byte; the state moves on when the byte is passed to the result register.
// ----------------------------------------------------------------------------
module cct_core
    import cct_pkg::*;
#(
    parameter int MAX_TOKEN_COUNT = 64,
    parameter int TOKEN_LEN       = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output result_t    res
);

    localparam int CW = $clog2(MAX_TOKEN_COUNT + 1);
    localparam int RW = $clog2(TOKEN_LEN);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TOKEN_COUNT);
    localparam logic [RW-1:0] RUN_MAX   = RW'(TOKEN_LEN - 1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_WORD   = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [RW-1:0] run_reg, run_next;
    logic [CW-1:0] count_reg, count_next;
    char_class_t cls;
    logic        in_run;
    logic        cont_num;
    logic        cont_word;

    cct_classify u_classify (
        .char_in (char_in),
        .cls     (cls)
    );

    // result and next state for this byte
    always_comb
    begin
        in_run    = (run_reg < RUN_MAX) && (count_reg != '0);
        cont_num  = in_run && (mode_reg == MODE_NUMBER) && (cls.digit || cls.dot);
        cont_word = in_run && (mode_reg == MODE_WORD) && cls.alpha;

        mode_next  = mode_reg;
        run_next   = run_reg;
        count_next = count_reg;

        res.kind        = KIND_SPACE;
        res.token_type  = TYPE_WORD;
        res.char_out    = char_in;
        res.token_start = 1'b0;
        res.token_index = '0;
        res.token_total = 7'(count_reg);

        if (cls.nul)
        begin
            // end of string: report the count and clear
            res.kind     = KIND_END;
            res.char_out = CHAR_NUL;
            mode_next    = MODE_IDLE;
            run_next     = '0;
            count_next   = '0;
        end
        else if (cont_num || cont_word)
        begin
            // byte continues the open token
            run_next        = run_reg + 1'b1;
            res.kind        = KIND_TOKEN;
            res.token_type  = cont_num ? TYPE_NUMBER : TYPE_WORD;
            res.char_out    = cls.lowered;
            res.token_index = 6'(count_reg - 1'b1);
        end
        else
        begin
            mode_next = MODE_IDLE;
            run_next  = '0;
            if (count_reg >= COUNT_MAX)
            begin
                res.kind = KIND_DROP;
            end
            else if (cls.space)
            begin
                res.kind = KIND_SPACE;
            end
            else
            begin
                // byte opens a new token
                count_next      = count_reg + 1'b1;
                res.kind        = KIND_TOKEN;
                res.char_out    = cls.lowered;
                res.token_start = 1'b1;
                res.token_index = 6'(count_reg);
                res.token_total = 7'(count_next);
                if (cls.digit)
                begin
                    res.token_type = TYPE_NUMBER;
                    mode_next      = MODE_NUMBER;
                    run_next       = RW'(1);
                end
                else if (cls.alpha)
                begin
                    res.token_type = TYPE_WORD;
                    mode_next      = MODE_WORD;
                    run_next       = RW'(1);
                end
                else if (cls.punct)
                begin
                    res.token_type = TYPE_PUNCT;
                end
                else
                begin
                    res.token_type = TYPE_UNKNOWN;
                end
            end
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            run_reg   <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/char_class_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_tokenizer
// Byte-serial character class lexer with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : one input byte per word; a zero byte ends the string, reports
//            the token count and clears the scan state.
//   tokens : one result word per input byte, in order (kind, token type,
//            lowered byte, start flag, token index, running token count).
//   A byte is taken into the input register, then classified against the scan
//   state and written to the result register once that register is free or
//   its word is being taken; the result word is shown from that register.
//   Throughput is one byte per cycle while the result side takes each word;
//   the classifier and the counter update lie between the two registers.
//   A stalled result register holds its word; the input register still takes
//   one more byte, then bytes.ready falls until the result is taken.
//   Reset clears both valid flags and the scan state (no token open, counts
//   zero); the block is ready for a byte as soon as reset is released.
// ----------------------------------------------------------------------------
module char_class_tokenizer
    import cct_pkg::*;
#(
    parameter int MAX_TOKEN_COUNT = 64,
    parameter int TOKEN_LEN       = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    cct_byte_if.sink     bytes,
    cct_token_if.source  tokens
);

    logic       hold_valid_reg;
    logic [7:0] hold_char_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    core_res;
    logic       advance;
    logic       take;

    // handshakes
    assign advance     = hold_valid_reg && (!res_valid_reg || tokens.ready);
    assign bytes.ready = !hold_valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;

    cct_core #(
        .MAX_TOKEN_COUNT (MAX_TOKEN_COUNT),
        .TOKEN_LEN       (TOKEN_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .char_in (hold_char_reg),
        .res     (core_res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (tokens.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_char_reg <= bytes.char_in;
        end
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    // result word
    assign tokens.valid       = res_valid_reg;
    assign tokens.kind        = res_reg.kind;
    assign tokens.token_type  = res_reg.token_type;
    assign tokens.char_out    = res_reg.char_out;
    assign tokens.token_start = res_reg.token_start;
    assign tokens.token_index = res_reg.token_index;
    assign tokens.token_total = res_reg.token_total;

endmodule
